// ===== rtl/core/evf_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// evf_pkg
// Shared types, register indexes and helpers of the encoder velocity filter.
// ============================================================================
package evf_pkg;

    localparam int TS_W       = 32;
    localparam int CNT_W      = 16;
    localparam int WORD_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CPR_W      = 16;
    localparam int COEF_W     = 10;

    typedef logic [TS_W-1:0]         t_ts;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CFG_IDX_W-1:0]    t_cfg_idx;
    typedef logic [CFG_DATA_W-1:0]   t_cfg_data;
    typedef logic [CPR_W-1:0]        t_cpr;
    typedef logic [COEF_W-1:0]       t_coef;

    // configuration register indexes
    localparam t_cfg_idx CFG_COUNTS_PER_REV = 2'd0;
    localparam t_cfg_idx CFG_FILTER_NUM     = 2'd1;
    localparam t_cfg_idx CFG_FILTER_DEN     = 2'd2;

    // register reset values
    localparam t_cpr  CPR_RESET  = 16'd2048;
    localparam t_coef FNUM_RESET = 10'd1;
    localparam t_coef FDEN_RESET = 10'd10;

    localparam logic signed [32:0] MS_PER_MIN = 33'sd60000;

    // clamp a 45-bit signed quotient to the signed 32-bit range
    function automatic t_word sat32(input logic signed [44:0] v);
        t_word res;
        if (v > 45'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -45'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/evf_in_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// evf_in_if
// Input channel: one encoder sample per transfer.
// ============================================================================
interface evf_in_if import evf_pkg::*; ();
    logic valid;
    logic ready;
    t_ts  timestamp_ms;
    t_cnt encoder_count;

    modport source(output valid, output timestamp_ms, output encoder_count, input ready);
    modport sink(input valid, input timestamp_ms, input encoder_count, output ready);
endinterface

// ===== rtl/core/evf_out_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// evf_out_if
// Result channel: filtered and instant speed plus counter clear request.
// ============================================================================
interface evf_out_if import evf_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word rpm_filtered;
    t_word rpm_instant;
    logic  clear_counter;

    modport source(output valid, output rpm_filtered, output rpm_instant,
                   output clear_counter, input ready);
    modport sink(input valid, input rpm_filtered, input rpm_instant,
                 input clear_counter, output ready);
endinterface

// ===== rtl/core/encoder_velocity_filter_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// encoder_velocity_filter_top
// Encoder speed estimator with IIR low-pass, built on one shared multiplier
// and one shared restoring divider run by a small sequencer.
// ============================================================================
// Path: a first item, zero time step or zero counts_per_rev go from the check
// step to the output; else the rpm division and, with nonzero filter_den,
// the filter division run. The shared divider runs 31 rpm and 44 filter steps;
// input is ready only while the sequencer is idle, so one item is in at a time.
// Reset (i_rst_n low, synchronous): registers return to 2048 / 1 / 10, filter
// state and last timestamp clear, the next item is treated as the first.
// ============================================================================
module encoder_velocity_filter_top import evf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    evf_in_if.sink          i_item,
    evf_out_if.source       o_result,
    input  logic            i_cfg_we,
    input  t_cfg_idx        i_cfg_idx,
    input  t_cfg_data       i_cfg_data
);

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,  // wait for an input transfer
        S_CHK  = 11'b000_0000_0010,  // first item / zero dt / zero cpr
        S_MDEN = 11'b000_0000_0100,  // mult: counts_per_rev * dt
        S_MNUM = 11'b000_0000_1000,  // mult: enc * 60000
        S_DLD  = 11'b000_0001_0000,  // load divider (magnitude, sign)
        S_DIV  = 11'b000_0010_0000,  // one quotient bit per cycle
        S_QUO  = 11'b000_0100_0000,  // apply sign, pick next step
        S_MA   = 11'b000_1000_0000,  // mult: filter_num * rpm
        S_MB   = 11'b001_0000_0000,  // mult: (den - num) * filt
        S_ADD  = 11'b010_0000_0000,  // sum both filter products
        S_FIN  = 11'b100_0000_0000   // hand result to output register
    } t_state;

    localparam int DQ_W   = 44;   // divider dividend/quotient width
    localparam int DV_W   = 48;   // divisor width (cpr * dt)
    localparam int RPM_W  = 31;   // rpm dividend magnitude width
    localparam int DCNT_W = 6;

    t_state r_state, n_state;

    // configuration
    t_cpr  r_cpr;
    t_coef r_fnum, r_fden;

    // block state
    logic  r_started;
    t_ts   r_last;
    t_word r_filt;

    // item working registers
    t_ts   r_ts;
    t_cnt  r_cnt;
    t_ts   r_dt;
    t_word r_rpm;
    logic  r_phase;             // 0: rpm division, 1: filter division

    // shared multiplier
    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [49:0] r_prod;
    logic signed [49:0] r_acc;

    // shared divider
    logic [DQ_W-1:0]   r_q;
    logic [DV_W-1:0]   r_rem;
    logic [DV_W-1:0]   r_div;
    logic              r_neg;
    logic [DCNT_W-1:0] r_dcnt;

    // staged result and output register
    t_word r_res_filt, r_res_inst;
    logic  r_res_clr;
    logic  r_out_valid;
    t_word r_out_filt, r_out_inst;
    logic  r_out_clr;

    logic                 in_xfer;
    logic                 out_free;
    logic signed [15:0]   enc;
    logic signed [10:0]   w_old;
    logic signed [49:0]   div_src;
    logic [49:0]          div_mag;
    logic [DV_W:0]        rem_sh;
    logic                 rem_ge;
    logic signed [44:0]   q_signed;
    t_word                q_sat;
    t_ts                  dt_now;

    assign i_item.ready = (r_state == S_IDLE);
    assign in_xfer      = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_result.ready;

    assign o_result.valid         = r_out_valid;
    assign o_result.rpm_filtered  = r_out_filt;
    assign o_result.rpm_instant   = r_out_inst;
    assign o_result.clear_counter = r_out_clr;

    // count negated as 16-bit two's complement (0x8000 stays -32768)
    assign enc    = $signed(16'(~r_cnt + 16'd1));
    assign w_old  = $signed(11'({1'b0, r_fden} - {1'b0, r_fnum}));
    assign dt_now = r_ts - r_last;

    // ---------------- shared multiplier operand select ----------------
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MDEN: begin
                mul_a = $signed({1'b0, r_cpr});
                mul_b = $signed({1'b0, r_dt});
            end
            S_MNUM: begin
                mul_a = {enc[15], enc};
                mul_b = MS_PER_MIN;
            end
            S_MA: begin
                mul_a = $signed({7'b0, r_fnum});
                mul_b = {r_rpm[31], r_rpm};
            end
            S_MB: begin
                mul_a = {{6{w_old[10]}}, w_old};
                mul_b = {r_filt[31], r_filt};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // ---------------- divider datapath ----------------
    assign div_src  = r_phase ? r_acc : r_prod;
    assign div_mag  = div_src[49] ? 50'(50'd0 - div_src) : div_src;
    assign rem_sh   = {r_rem, r_q[DQ_W-1]};
    assign rem_ge   = rem_sh >= {1'b0, r_div};
    assign q_signed = r_neg ? $signed(45'(45'd0 - {1'b0, r_q})) : $signed({1'b0, r_q});
    assign q_sat    = sat32(q_signed);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_xfer) begin
                n_state = S_CHK;
            end
            S_CHK: begin
                if (!r_started || dt_now == '0 || r_cpr == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MDEN;
                end
            end
            S_MDEN: n_state = S_MNUM;
            S_MNUM: n_state = S_DLD;
            S_DLD:  n_state = S_DIV;
            S_DIV: if (r_dcnt == DCNT_W'(1)) begin
                n_state = S_QUO;
            end
            S_QUO: begin
                if (r_phase || r_fden == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_MA;
                end
            end
            S_MA:  n_state = S_MB;
            S_MB:  n_state = S_ADD;
            S_ADD: n_state = S_DLD;
            S_FIN: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cpr       <= CPR_RESET;
            r_fnum      <= FNUM_RESET;
            r_fden      <= FDEN_RESET;
            r_started   <= 1'b0;
            r_last      <= '0;
            r_filt      <= '0;
            r_out_valid <= 1'b0;
            r_phase     <= 1'b0;
            r_dcnt      <= '0;
        end else begin
            r_state <= n_state;

            // configuration writes; indexes past the list are ignored
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_COUNTS_PER_REV: r_cpr  <= i_cfg_data;
                    CFG_FILTER_NUM:     r_fnum <= i_cfg_data[COEF_W-1:0];
                    CFG_FILTER_DEN:     r_fden <= i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_CHK: begin
                    r_last <= r_ts;
                    if (!r_started) begin
                        r_started <= 1'b1;
                        r_filt    <= '0;
                    end
                end
                S_DLD: begin
                    r_dcnt <= r_phase ? DCNT_W'(DQ_W) : DCNT_W'(RPM_W);
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                end
                S_QUO: begin
                    if (r_phase) begin
                        r_filt <= q_sat;
                    end else if (r_fden == '0) begin
                        r_filt <= q_sat;
                    end
                    r_phase <= 1'b0;
                end
                S_ADD: begin
                    r_phase <= 1'b1;
                end
                default: ;
            endcase

            // output register: load from FIN, drop on a completed transfer
            if (r_state == S_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_prod <= 50'(mul_a) * 50'(mul_b);

        if (in_xfer) begin
            r_ts  <= i_item.timestamp_ms;
            r_cnt <= i_item.encoder_count;
        end

        case (r_state)
            S_CHK: begin
                r_dt <= dt_now;
                if (!r_started) begin
                    r_res_filt <= '0;
                    r_res_inst <= '0;
                    r_res_clr  <= 1'b1;
                end else begin
                    // zero dt holds and skips the clear; zero cpr holds and clears
                    r_res_filt <= r_filt;
                    r_res_inst <= '0;
                    r_res_clr  <= (dt_now != '0);
                end
            end
            S_MNUM: begin
                r_div <= r_prod[DV_W-1:0];
            end
            S_DLD: begin
                r_neg <= div_src[49];
                r_rem <= '0;
                if (r_phase) begin
                    r_q <= div_mag[DQ_W-1:0];
                end else begin
                    // left-align so 31 steps leave the quotient in the low bits
                    r_q <= {div_mag[RPM_W-1:0], {(DQ_W-RPM_W){1'b0}}};
                end
            end
            S_DIV: begin
                r_rem <= rem_ge ? DV_W'(rem_sh - {1'b0, r_div}) : rem_sh[DV_W-1:0];
                r_q   <= {r_q[DQ_W-2:0], rem_ge};
            end
            S_QUO: begin
                r_res_clr <= 1'b1;
                if (r_phase) begin
                    r_res_filt <= q_sat;
                    r_res_inst <= r_rpm;
                end else begin
                    r_rpm      <= q_sat;
                    r_res_filt <= q_sat;
                    r_res_inst <= q_sat;
                end
            end
            S_MB: begin
                r_acc <= r_prod;
            end
            S_ADD: begin
                r_acc <= r_acc + r_prod;
                r_div <= DV_W'(r_fden);
            end
            default: ;
        endcase

        if (r_state == S_FIN && out_free) begin
            r_out_filt <= r_res_filt;
            r_out_inst <= r_res_inst;
            r_out_clr  <= r_res_clr;
        end
    end

`ifndef SYNTHESIS
    // an accepted item always starts at the check step
    a_accept_to_chk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == S_CHK)
        else $error("sequencer did not leave idle on input transfer");

    // restoring divider keeps its partial remainder below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_div)
        else $error("divider remainder not below divisor");

    // the divider is never entered with an exhausted step count
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_dcnt != '0)
        else $error("divider running with zero step count");

    // rpm quotient fits in 31 bits
    a_rpm_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUO && !r_phase) |-> r_q[DQ_W-1:RPM_W] == '0)
        else $error("rpm quotient overflowed");
`endif

endmodule

// ===== tb/encoder_velocity_filter_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// encoder_velocity_filter_top_tb
// Self-checking bench for the encoder speed estimator. Each accepted encoder
// sample runs through a local speed/IIR estimator, and every result transfer
// is compared field by field against the oldest pending estimate. The run
// starts with a table of directed samples and register writes. Random phases
// follow, with several filter settings and with sender and receiver throttling.
// ============================================================================
module encoder_velocity_filter_top_tb;
    import evf_pkg::*;

    localparam int     CLK_HALF      = 10;
    localparam int     RESET_CYCLES  = 11;
    localparam int     PHASES        = 3;
    localparam int     CHUNKS        = 5;
    localparam int     CHUNK_ITEMS   = 50;
    localparam int     STALL_LIMIT   = 5000;  // quiet cycles before giving up
    localparam int     SETTLE_CYCLES = 100;   // settle wait before the verdict
    localparam int     HOLD_CYCLES   = 600;   // long receiver back-pressure
    localparam longint MS_PER_MINUTE = 60000;

    // one result transfer
    typedef struct packed {
        t_word filt;
        t_word inst;
        logic  clr;
    } speed_result_t;

    // directed table: either a sample or a register write
    typedef enum logic {ROW_SAMPLE, ROW_WRITE} plan_kind_e;

    typedef struct packed {
        plan_kind_e kind;
        t_ts        ts;
        t_cnt       cnt;
        t_cfg_idx   reg_idx;
        t_cfg_data  reg_val;
        logic       is_typed;  // expected result given in the row
        t_word      exp_filt;
        t_word      exp_inst;
        logic       exp_clr;
    } plan_row_t;

    // Rows with is_typed set carry their result by hand: first sample after
    // reset, zero time step, counter extremes and filter saturation. All other
    // rows are checked against the estimator.
    localparam plan_row_t DIRECTED_PLAN [32] = '{
        // reset defaults: 2048 counts/rev, weight 1/10
        '{ROW_SAMPLE, 32'd1000, 16'h1234, '0, '0, 1'b1, 32'sd0, 32'sd0, 1'b1},
        '{ROW_SAMPLE, 32'd1000, 16'h0005, '0, '0, 1'b1, 32'sd0, 32'sd0, 1'b0},
        '{ROW_SAMPLE, 32'd1010, 16'h0000, '0, '0, 1'b1, 32'sd0, 32'sd0, 1'b1},
        '{ROW_SAMPLE, 32'd1020, 16'h8000, '0, '0, 1'b1, -32'sd9600, -32'sd96000, 1'b1},
        '{ROW_SAMPLE, 32'd1021, 16'hFFFF, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd1031, 16'h0001, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd1041, 16'h7FFF, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd1051, 16'h8001, '0, '0, 1'b0, '0, '0, 1'b0},
        // huge step, then time wraps past zero
        '{ROW_SAMPLE, 32'hFFFF_FFF0, 16'h0100, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0010, 16'hFF00, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'hFFFF_FFFF, 16'h0200, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'h0000_0000, 16'hFE00, '0, '0, 1'b0, '0, '0, 1'b0},
        // zero counts/rev holds the filter, then a zero time step
        '{ROW_WRITE, '0, '0, CFG_COUNTS_PER_REV, 16'h0000, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd5, 16'h4000, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd5, 16'h1111, '0, '0, 1'b0, '0, '0, 1'b0},
        // zero denominator passes rpm straight through (upper bits ignored)
        '{ROW_WRITE, '0, '0, CFG_COUNTS_PER_REV, 16'h0001, 1'b0, '0, '0, 1'b0},
        '{ROW_WRITE, '0, '0, CFG_FILTER_DEN, 16'hFC00, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd6, 16'h8000, '0, '0, 1'b1,
          -32'sd1966080000, -32'sd1966080000, 1'b1},
        // numerator above denominator: saturate high, then low
        '{ROW_WRITE, '0, '0, CFG_FILTER_NUM, 16'hFFFF, 1'b0, '0, '0, 1'b0},
        '{ROW_WRITE, '0, '0, CFG_FILTER_DEN, 16'h0001, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd7, 16'h8001, '0, '0, 1'b1,
          32'sh7FFF_FFFF, 32'sd1966020000, 1'b1},
        '{ROW_SAMPLE, 32'd8, 16'h8000, '0, '0, 1'b1,
          32'sh8000_0000, -32'sd1966080000, 1'b1},
        // zero numerator freezes the filter, full numerator follows rpm
        '{ROW_WRITE, '0, '0, CFG_FILTER_NUM, 16'hFC00, 1'b0, '0, '0, 1'b0},
        '{ROW_WRITE, '0, '0, CFG_FILTER_DEN, 16'h03FF, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd9, 16'h0123, '0, '0, 1'b0, '0, '0, 1'b0},
        '{ROW_WRITE, '0, '0, CFG_FILTER_NUM, 16'h03FF, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'd10, 16'h0456, '0, '0, 1'b0, '0, '0, 1'b0},
        // largest counts/rev with a 2^31 ms step
        '{ROW_WRITE, '0, '0, CFG_COUNTS_PER_REV, 16'hFFFF, 1'b0, '0, '0, 1'b0},
        '{ROW_SAMPLE, 32'h8000_000A, 16'h8000, '0, '0, 1'b0, '0, '0, 1'b0},
        // back to reset defaults
        '{ROW_WRITE, '0, '0, CFG_COUNTS_PER_REV, CPR_RESET, 1'b0, '0, '0, 1'b0},
        '{ROW_WRITE, '0, '0, CFG_FILTER_NUM, 16'h0001, 1'b0, '0, '0, 1'b0},
        '{ROW_WRITE, '0, '0, CFG_FILTER_DEN, 16'h000A, 1'b0, '0, '0, 1'b0}
    };

    localparam t_cnt COUNT_EDGES [6] = '{16'h0000, 16'h0001, 16'h7FFF,
                                         16'h8000, 16'h8001, 16'hFFFF};

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_idx;
    t_cfg_data i_cfg_data;

    evf_in_if  in_ch ();
    evf_out_if out_ch ();

    encoder_velocity_filter_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (in_ch),
        .o_result   (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // estimator copy of the registers and the filter state
    t_cpr  cfg_cpr  = CPR_RESET;
    t_coef cfg_fnum = FNUM_RESET;
    t_coef cfg_fden = FDEN_RESET;
    logic  est_started = 1'b0;
    t_ts   est_last_ts = '0;
    t_word est_filt    = '0;

    speed_result_t pending_speeds[$];  // estimates waiting for their transfer
    int            mismatch_count = 0;
    int            tx_idle_pct    = 20;
    int            rx_idle_pct    = 58;
    int            rx_hold_cycles = 0;  // request for a long receiver stall

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic t_word clamp_word(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return t_word'(v);
    endfunction

    // rpm and IIR update for one sample; advances the estimator state
    function automatic speed_result_t estimate_speed(input t_ts ts, input t_cnt cnt);
        speed_result_t r;
        t_ts           dt;
        logic signed [CNT_W-1:0] ticks;
        longint        rate_den;
        longint        rpm;
        longint        blend;
        r.filt = '0;
        r.inst = '0;
        r.clr  = 1'b1;
        if (!est_started) begin
            est_started = 1'b1;
            est_last_ts = ts;
            est_filt    = '0;
            return r;
        end
        dt          = ts - est_last_ts;
        est_last_ts = ts;
        r.filt      = est_filt;
        if (dt == '0) begin
            r.clr = 1'b0;
            return r;
        end
        // counter runs backwards: negate modulo 2^16
        ticks    = t_cnt'(16'd0 - cnt);
        rate_den = longint'(cfg_cpr) * longint'(dt);
        if (rate_den == 0) begin
            return r;
        end
        rpm = (longint'(ticks) * MS_PER_MINUTE) / rate_den;
        if (cfg_fden == '0) begin
            est_filt = clamp_word(rpm);
        end else begin
            blend = (longint'(cfg_fnum) * rpm +
                     (longint'(cfg_fden) - longint'(cfg_fnum)) * longint'(est_filt)) /
                    longint'(cfg_fden);
            est_filt = clamp_word(blend);
        end
        r.filt = est_filt;
        r.inst = clamp_word(rpm);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_speed(input speed_result_t got);
        speed_result_t want;
        if (pending_speeds.size() == 0) begin
            report_mismatch("unexpected result", got.filt, 0);
            return;
        end
        want = pending_speeds.pop_front();
        if (got.filt !== want.filt) begin
            report_mismatch("rpm_filtered", got.filt, want.filt);
        end
        if (got.inst !== want.inst) begin
            report_mismatch("rpm_instant", got.inst, want.inst);
        end
        if (got.clr !== want.clr) begin
            report_mismatch("clear_counter", got.clr, want.clr);
        end
    endtask

    // one register write, followed by a wait with the write enable low, so back-to-back
    // writes never stack two updates of the write enable in the same step
    task automatic write_reg(input t_cfg_idx idx, input t_cfg_data val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_COUNTS_PER_REV: cfg_cpr  = val;
            CFG_FILTER_NUM:     cfg_fnum = val[COEF_W-1:0];
            CFG_FILTER_DEN:     cfg_fden = val[COEF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offer one sample; valid stays high after the transfer so the next call
    // can stream without a bubble.
    task automatic send_sample(input t_ts ts, input t_cnt cnt, input logic is_typed,
                               input speed_result_t typed_exp);
        speed_result_t predicted;
        if ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat (($urandom_range(9) == 0) ? $urandom_range(7, 120) : $urandom_range(1, 6))
                @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.timestamp_ms  <= ts;
        in_ch.encoder_count <= cnt;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predicted = estimate_speed(ts, cnt);
        pending_speeds.push_back(is_typed ? typed_exp : predicted);
    endtask

    // sender pauses until every pending result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_speeds.size() != 0) @(posedge i_clk);
    endtask

    // Filter settings per chunk: the extremes first, then a pass-through (zero
    // denominator), a held filter (zero counts/rev), defaults and random mixes.
    // Upper data bits of the 10-bit coefficients are random and must be dropped.
    task automatic program_filter(input int sel);
        t_cpr  cpr;
        t_coef fnum;
        t_coef fden;
        case (sel)
            0: begin
                cpr  = 16'd1;
                fnum = 10'd0;
                fden = 10'd1023;
            end
            1: begin
                cpr  = 16'hFFFF;
                fnum = 10'd1023;
                fden = 10'd1023;
            end
            2: begin
                cpr  = t_cpr'($urandom_range(1, 4096));
                fnum = t_coef'($urandom());
                fden = '0;
            end
            3: begin
                cpr  = '0;
                fnum = FNUM_RESET;
                fden = FDEN_RESET;
            end
            4: begin
                cpr  = CPR_RESET;
                fnum = FNUM_RESET;
                fden = FDEN_RESET;
            end
            default: begin
                fden = t_coef'($urandom_range(1, 1023));
                fnum = ($urandom_range(4) == 0) ? t_coef'($urandom())
                                                : t_coef'($urandom_range(0, fden));
                cpr  = $urandom_range(1) ? t_cpr'($urandom_range(1, 4096))
                                         : t_cpr'($urandom());
            end
        endcase
        write_reg(CFG_COUNTS_PER_REV, cpr);
        write_reg(CFG_FILTER_NUM, {6'($urandom()), fnum});
        write_reg(CFG_FILTER_DEN, {6'($urandom()), fden});
    endtask

    // Result side: check each transfer, then pick ready for the next edge.
    // A hold request stalls ready for a counted stretch so the block backs up
    // and drops its input ready.
    initial begin : result_sink
        speed_result_t got;
        int            hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                got.filt = out_ch.rpm_filtered;
                got.inst = out_ch.rpm_instant;
                got.clr  = out_ch.clear_counter;
                check_speed(got);
            end
            if (rx_hold_cycles != 0) begin
                hold_left      = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog: ends the run after too many cycles with no transfer at all
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
                (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        speed_result_t typed_exp;
        t_ts           clock_ms;
        t_ts           step_ms;
        t_cnt          cnt;
        int            phase;
        int            chunk;
        int            n;
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= '0;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.timestamp_ms  <= '0;
        in_ch.encoder_count <= '0;
        clock_ms = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, with the first throttling mix
        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(DIRECTED_PLAN[i].reg_idx, DIRECTED_PLAN[i].reg_val);
            end else begin
                typed_exp.filt = DIRECTED_PLAN[i].exp_filt;
                typed_exp.inst = DIRECTED_PLAN[i].exp_inst;
                typed_exp.clr  = DIRECTED_PLAN[i].exp_clr;
                send_sample(DIRECTED_PLAN[i].ts, DIRECTED_PLAN[i].cnt,
                            DIRECTED_PLAN[i].is_typed, typed_exp);
                clock_ms = DIRECTED_PLAN[i].ts;
            end
        end

        // random phases: sender-light/receiver-heavy idling, then the
        // reverse, then full rate
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 20;
                    rx_idle_pct = 58;
                end
                1: begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 20;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (chunk = 0; chunk < CHUNKS; chunk++) begin
                // registers change only with nothing in flight
                drain_results();
                program_filter((phase * CHUNKS + chunk) % 7);
                if (phase == 0 && chunk == 0) begin
                    rx_hold_cycles = HOLD_CYCLES;
                end
                for (n = 0; n < CHUNK_ITEMS; n++) begin
                    // mostly short control periods, some repeats and long or
                    // wrapping gaps
                    case ($urandom_range(9))
                        0:       step_ms = '0;
                        1:       step_ms = $urandom();
                        2, 3:    step_ms = $urandom_range(51, 65535);
                        default: step_ms = $urandom_range(1, 50);
                    endcase
                    clock_ms += step_ms;
                    case ($urandom_range(9))
                        0, 1, 2, 3: cnt = t_cnt'($urandom());
                        4, 5, 6:    cnt = t_cnt'($urandom_range(4000) - 2000);
                        default:    cnt = COUNT_EDGES[$urandom_range(5)];
                    endcase
                    send_sample(clock_ms, cnt, 1'b0, '0);
                end
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/evf_pkg.sv
rtl/core/evf_in_if.sv
rtl/core/evf_out_if.sv
rtl/core/encoder_velocity_filter_top.sv
tb/encoder_velocity_filter_top_tb.sv
